// ===== rtl/qsa_pkg.sv =====
package qsa_pkg;

  localparam int QW         = 16;
  localparam int FW         = 32;
  localparam int SPW        = FW - 1;
  localparam int ROOT_W     = 30;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int SQ_STEPS   = ROOT_W;
  localparam int DIV_STEPS  = ROOT_W;
  localparam int SQRT_LAT   = SQ_STEPS + 2;
  localparam int DIV_LAT    = DIV_STEPS + 2;
  localparam int TOTAL_LAT  = SQRT_LAT + DIV_LAT + 11;
  localparam int Q_W        = ROOT_W + 1;
  localparam int NUM_SHIFT  = 42;
  localparam int FRAC_SHIFT = 14;
  localparam int RAD_SHIFT  = 28;
  localparam int SUM_W      = 32;

  localparam logic [SUM_W-1:0] ONE_Q28     = 32'h1000_0000;
  localparam logic [SUM_W-1:0] DEGEN_S_MAX = 32'h0FFF_FFE5;
  localparam logic [SPW-1:0]   ONE_Q16     = 31'h0001_0000;

  typedef struct packed {
    logic signed [QW-1:0] quat_b;
    logic signed [QW-1:0] quat_c;
    logic signed [QW-1:0] quat_d;
    logic signed [FW-1:0] offset_x;
    logic signed [FW-1:0] offset_y;
    logic signed [FW-1:0] offset_z;
    logic signed [FW-1:0] spacing_x;
    logic signed [FW-1:0] spacing_y;
    logic signed [FW-1:0] spacing_z;
    logic                 left_handed;
  } item_t;

  typedef struct packed {
    logic signed [FW-1:0] m00;
    logic signed [FW-1:0] m01;
    logic signed [FW-1:0] m02;
    logic signed [FW-1:0] m10;
    logic signed [FW-1:0] m11;
    logic signed [FW-1:0] m12;
    logic signed [FW-1:0] m20;
    logic signed [FW-1:0] m21;
    logic signed [FW-1:0] m22;
    logic signed [FW-1:0] trans_x;
    logic signed [FW-1:0] trans_y;
    logic signed [FW-1:0] trans_z;
  } result_t;

  typedef struct packed {
    logic                  degen;
    logic signed [QW-1:0]  qb;
    logic signed [QW-1:0]  qc;
    logic signed [QW-1:0]  qd;
    logic [ROOT_W-1:0]     a_root;
    logic signed [FW-1:0]  ox;
    logic signed [FW-1:0]  oy;
    logic signed [FW-1:0]  oz;
    logic [2:0][SPW-1:0]   sp;
    logic                  neg_z;
  } side_t;

endpackage

// ===== rtl/quaternion_to_scaled_affine_core.sv =====
// Throughput: one transfer per cycle; depth is set by the 30-step root pipeline
// and the 30-step three-lane divider pipeline that follows it.
// busy stays low; each result is on the ports for one cycle with done and the
// receiver cannot stall it. Synchronous rst clears all stage valids.
module quaternion_to_scaled_affine_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  qsa_pkg::item_t   operand,
  output logic             done,
  output qsa_pkg::result_t result
);
  import qsa_pkg::*;

  localparam int PROD_W = 2 * Q_W;
  localparam int TERM_W = 64;
  localparam int MSH    = 26;
  localparam int RND_W  = TERM_W - MSH;
  localparam int PM_W   = FW + SPW;
  localparam int PSH    = 30;
  localparam int PR_W   = PM_W - PSH;
  localparam int NT     = 9;

  localparam logic [TERM_W-1:0] RND_T    = TERM_W'(1) << (MSH - 1);
  localparam logic [PM_W-1:0]   RND_P    = PM_W'(1) << (PSH - 1);
  localparam logic [FW-1:0]     T_CLAMP  = 32'h8000_0000;
  localparam logic [FW-1:0]     POS_MAX  = 32'h7FFF_FFFF;
  localparam logic [FW-1:0]     NEG_MIN  = 32'h8000_0000;
  localparam logic signed [Q_W-1:0] QUO_LIM = Q_W'(32'sd268435458);

  function automatic logic [SPW-1:0] sp_fix(input logic signed [FW-1:0] v);
    return (v <= 0) ? ONE_Q16 : v[SPW-1:0];
  endfunction

  logic vld_a, vld_b, vld_c, vld_e, vld_f, vld_g, vld_h, vld_i, vld_j, vld_k;

  item_t                    op_a;
  side_t                    side_a, side_b, side_c, side_c1;
  logic signed [2*QW-1:0]   sqp [3];
  logic [2*QW-1:0]          sq_b [3];
  logic [SUM_W-1:0]         s_c;
  logic                     degen_c;
  logic [SUM_W-1:0]         asq_c;
  logic [RAD_W-1:0]         rad_c;

  side_t                    line1 [SQRT_LAT];
  side_t                    line2 [DIV_LAT];
  side_t                    side_s, side_s1, side_d;
  logic                     sq_valid, div_valid;
  logic [ROOT_W-1:0]        sq_root;
  logic signed [Q_W-1:0]    quo_b, quo_c, quo_d;

  side_t                    side_e, side_f, side_g, side_h, side_i, side_j, side_k;
  logic signed [Q_W-1:0]    qa_e, qb_e, qc_e, qd_e;
  logic signed [PROD_W-1:0] aa_f, bb_f, cc_f, dd_f, ab_f, ac_f, ad_f, bc_f, bd_f, cd_f;
  logic signed [TERM_W-1:0] d_g [6];
  logic signed [TERM_W-1:0] off_g [6];
  logic signed [TERM_W-1:0] term_h [NT];
  logic [TERM_W-1:0]        mag_i [NT];
  logic                     neg_i [NT];
  logic [TERM_W-1:0]        rs_j [NT];
  logic [RND_W-1:0]         rq_j [NT];
  logic [FW-1:0]            m_j [NT];
  logic                     neg_j [NT];
  logic [PM_W-1:0]          prod_k [NT];
  logic                     neg_k [NT];
  logic [PM_W-1:0]          ps_l [NT];
  logic [PR_W-1:0]          pr_l [NT];
  logic [FW-1:0]            sat_l [NT];
  logic [2:0]               col_neg;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      vld_e <= 1'b0;
      vld_f <= 1'b0;
      vld_g <= 1'b0;
      vld_h <= 1'b0;
      vld_i <= 1'b0;
      vld_j <= 1'b0;
      vld_k <= 1'b0;
      done  <= 1'b0;
    end else begin
      vld_a <= start && !busy;
      vld_b <= vld_a;
      vld_c <= vld_b;
      vld_e <= div_valid;
      vld_f <= vld_e;
      vld_g <= vld_f;
      vld_h <= vld_g;
      vld_i <= vld_h;
      vld_j <= vld_i;
      vld_k <= vld_j;
      done  <= vld_k;
    end
  end

  // front end: squares, sum, degenerate test
  assign sqp[0] = op_a.quat_b * op_a.quat_b;
  assign sqp[1] = op_a.quat_c * op_a.quat_c;
  assign sqp[2] = op_a.quat_d * op_a.quat_d;

  always_comb begin
    side_a        = '0;
    side_a.qb     = op_a.quat_b;
    side_a.qc     = op_a.quat_c;
    side_a.qd     = op_a.quat_d;
    side_a.ox     = op_a.offset_x;
    side_a.oy     = op_a.offset_y;
    side_a.oz     = op_a.offset_z;
    side_a.sp[0]  = sp_fix(op_a.spacing_x);
    side_a.sp[1]  = sp_fix(op_a.spacing_y);
    side_a.sp[2]  = sp_fix(op_a.spacing_z);
    side_a.neg_z  = op_a.left_handed;
  end

  always_comb begin
    degen_c       = s_c > DEGEN_S_MAX;
    asq_c         = ONE_Q28 - s_c;
    rad_c         = degen_c ? (RAD_W'(s_c) << RAD_SHIFT) : (RAD_W'(asq_c) << RAD_SHIFT);
    side_c1       = side_c;
    side_c1.degen = degen_c;
  end

  always_ff @(posedge clk) begin
    op_a   <= operand;
    side_b <= side_a;
    for (int i = 0; i < 3; i++) begin
      sq_b[i] <= sqp[i];
    end
    side_c <= side_b;
    s_c    <= sq_b[0] + sq_b[1] + sq_b[2];
  end

  // side data delay lines aligned to root and divider pipelines
  always_comb begin
    side_s         = line1[SQRT_LAT-1];
    side_s1        = side_s;
    side_s1.a_root = sq_root;
    side_d         = line2[DIV_LAT-1];
  end

  always_ff @(posedge clk) begin
    line1[0] <= side_c1;
    for (int k = 1; k < SQRT_LAT; k++) begin
      line1[k] <= line1[k-1];
    end
    line2[0] <= side_s1;
    for (int k = 1; k < DIV_LAT; k++) begin
      line2[k] <= line2[k-1];
    end
  end

  qsa_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_c),
    .radicand  (rad_c),
    .out_valid (sq_valid),
    .root      (sq_root)
  );

  qsa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .divisor   (sq_root),
    .num_b     (side_s.qb),
    .num_c     (side_s.qc),
    .num_d     (side_s.qd),
    .out_valid (div_valid),
    .quo_b     (quo_b),
    .quo_c     (quo_c),
    .quo_d     (quo_d)
  );

  // back end
  assign col_neg = {side_j.neg_z, 2'b00};

  always_comb begin
    for (int i = 0; i < NT; i++) begin
      rs_j[i]  = mag_i[i] + RND_T;
      rq_j[i]  = rs_j[i][TERM_W-1:MSH];
      ps_l[i]  = prod_k[i] + RND_P;
      pr_l[i]  = ps_l[i][PM_W-1:PSH];
      if (neg_k[i]) begin
        sat_l[i] = (pr_l[i] > PR_W'(NEG_MIN)) ? NEG_MIN : -pr_l[i][FW-1:0];
      end else begin
        sat_l[i] = (pr_l[i] > PR_W'(POS_MAX)) ? POS_MAX : pr_l[i][FW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    side_e <= side_d;
    qa_e   <= side_d.degen ? '0 : Q_W'(side_d.a_root);
    qb_e   <= side_d.degen ? quo_b : (Q_W'(side_d.qb) <<< FRAC_SHIFT);
    qc_e   <= side_d.degen ? quo_c : (Q_W'(side_d.qc) <<< FRAC_SHIFT);
    qd_e   <= side_d.degen ? quo_d : (Q_W'(side_d.qd) <<< FRAC_SHIFT);

    side_f <= side_e;
    aa_f   <= qa_e * qa_e;
    bb_f   <= qb_e * qb_e;
    cc_f   <= qc_e * qc_e;
    dd_f   <= qd_e * qd_e;
    ab_f   <= qa_e * qb_e;
    ac_f   <= qa_e * qc_e;
    ad_f   <= qa_e * qd_e;
    bc_f   <= qb_e * qc_e;
    bd_f   <= qb_e * qd_e;
    cd_f   <= qc_e * qd_e;

    side_g   <= side_f;
    d_g[0]   <= TERM_W'(aa_f) + TERM_W'(bb_f);
    d_g[1]   <= TERM_W'(cc_f) + TERM_W'(dd_f);
    d_g[2]   <= TERM_W'(aa_f) + TERM_W'(cc_f);
    d_g[3]   <= TERM_W'(bb_f) + TERM_W'(dd_f);
    d_g[4]   <= TERM_W'(aa_f) + TERM_W'(dd_f);
    d_g[5]   <= TERM_W'(bb_f) + TERM_W'(cc_f);
    off_g[0] <= (TERM_W'(bc_f) - TERM_W'(ad_f)) <<< 1;
    off_g[1] <= (TERM_W'(bd_f) + TERM_W'(ac_f)) <<< 1;
    off_g[2] <= (TERM_W'(bc_f) + TERM_W'(ad_f)) <<< 1;
    off_g[3] <= (TERM_W'(cd_f) - TERM_W'(ab_f)) <<< 1;
    off_g[4] <= (TERM_W'(bd_f) - TERM_W'(ac_f)) <<< 1;
    off_g[5] <= (TERM_W'(cd_f) + TERM_W'(ab_f)) <<< 1;

    side_h    <= side_g;
    term_h[0] <= d_g[0] - d_g[1];
    term_h[1] <= off_g[0];
    term_h[2] <= off_g[1];
    term_h[3] <= off_g[2];
    term_h[4] <= d_g[2] - d_g[3];
    term_h[5] <= off_g[3];
    term_h[6] <= off_g[4];
    term_h[7] <= off_g[5];
    term_h[8] <= d_g[4] - d_g[5];

    side_i <= side_h;
    for (int i = 0; i < NT; i++) begin
      neg_i[i] <= term_h[i][TERM_W-1];
      mag_i[i] <= term_h[i][TERM_W-1] ? -term_h[i] : term_h[i];
    end

    side_j <= side_i;
    for (int i = 0; i < NT; i++) begin
      neg_j[i] <= neg_i[i];
      m_j[i]   <= (rq_j[i] > RND_W'(T_CLAMP)) ? T_CLAMP : rq_j[i][FW-1:0];
    end

    side_k <= side_j;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_k[r*3+c] <= m_j[r*3+c] * side_j.sp[c];
        neg_k[r*3+c]  <= neg_j[r*3+c] ^ col_neg[c];
      end
    end

    result.m00     <= sat_l[0];
    result.m01     <= sat_l[1];
    result.m02     <= sat_l[2];
    result.m10     <= sat_l[3];
    result.m11     <= sat_l[4];
    result.m12     <= sat_l[5];
    result.m20     <= sat_l[6];
    result.m21     <= sat_l[7];
    result.m22     <= sat_l[8];
    result.trans_x <= side_k.ox;
    result.trans_y <= side_k.oy;
    result.trans_z <= side_k.oz;
  end

  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##TOTAL_LAT done)
    else $error("transfer without done at fixed latency");

  a_lat_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("done without matching start transfer");

  a_root_rng: assert property (@(posedge clk) disable iff (rst)
    (sq_valid && !side_s.degen) |-> (sq_root <= ROOT_W'(ONE_Q28)))
    else $error("real part above one");

  a_quo_rng: assert property (@(posedge clk) disable iff (rst)
    (div_valid && side_d.degen) |->
      ((quo_b <= QUO_LIM) && (quo_b >= -QUO_LIM) &&
       (quo_c <= QUO_LIM) && (quo_c >= -QUO_LIM) &&
       (quo_d <= QUO_LIM) && (quo_d >= -QUO_LIM)))
    else $error("normalized component out of range");

endmodule

// ===== rtl/qsa_sqrt.sv =====
module qsa_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [qsa_pkg::RAD_W-1:0]    radicand,
  output logic                         out_valid,
  output logic [qsa_pkg::ROOT_W-1:0]   root
);
  import qsa_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  logic [SQ_STEPS+1:0] vld;
  logic [REM_W-1:0]    rem [SQ_STEPS+1];
  logic [ROOT_W-1:0]   rt [SQ_STEPS+1];
  logic [RAD_W-1:0]    xr [SQ_STEPS];
  logic [REM_W-1:0]    cur [SQ_STEPS];
  logic [REM_W-1:0]    trial [SQ_STEPS];
  logic                take [SQ_STEPS];

  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      cur[k]   = {rem[k][REM_W-3:0], xr[k][RAD_W-1 -: 2]};
      trial[k] = {1'b0, rt[k], 2'b01};
      take[k]  = cur[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[SQ_STEPS:0], in_valid};
    end
    rem[0] <= '0;
    rt[0]  <= '0;
    xr[0]  <= radicand;
    for (int k = 0; k < SQ_STEPS - 1; k++) begin
      xr[k+1] <= xr[k] << 2;
    end
    for (int k = 0; k < SQ_STEPS; k++) begin
      rem[k+1] <= take[k] ? (cur[k] - trial[k]) : cur[k];
      rt[k+1]  <= {rt[k][ROOT_W-2:0], take[k]};
    end
    // round to nearest: bump when remainder exceeds root
    root <= rt[SQ_STEPS] + ROOT_W'(rem[SQ_STEPS] > REM_W'(rt[SQ_STEPS]));
  end

  assign out_valid = vld[SQ_STEPS+1];

endmodule

// ===== rtl/qsa_div.sv =====
module qsa_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [qsa_pkg::ROOT_W-1:0]        divisor,
  input  logic signed [qsa_pkg::QW-1:0]     num_b,
  input  logic signed [qsa_pkg::QW-1:0]     num_c,
  input  logic signed [qsa_pkg::QW-1:0]     num_d,
  output logic                              out_valid,
  output logic signed [qsa_pkg::Q_W-1:0]    quo_b,
  output logic signed [qsa_pkg::Q_W-1:0]    quo_c,
  output logic signed [qsa_pkg::Q_W-1:0]    quo_d
);
  import qsa_pkg::*;

  localparam int LANES = 3;
  localparam int ACC_W = 2 * DIV_STEPS + 1;
  localparam int TOP_W = ACC_W - DIV_STEPS;

  logic [DIV_STEPS+1:0]  vld;
  logic [ROOT_W-1:0]     dv [DIV_STEPS];
  logic [ACC_W-1:0]      acc [DIV_STEPS+1][LANES];
  logic                  neg [DIV_STEPS+1][LANES];
  logic signed [QW-1:0]  num [LANES];
  logic [QW-1:0]         mag [LANES];
  logic [ACC_W-1:0]      sh [DIV_STEPS][LANES];
  logic [TOP_W-1:0]      top_r [DIV_STEPS][LANES];
  logic                  fits [DIV_STEPS][LANES];
  logic signed [Q_W-1:0] quo [LANES];

  assign num[0] = num_b;
  assign num[1] = num_c;
  assign num[2] = num_d;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l] = num[l][QW-1] ? QW'(-num[l]) : num[l];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int l = 0; l < LANES; l++) begin
        sh[k][l]    = acc[k][l] << 1;
        top_r[k][l] = sh[k][l][ACC_W-1:DIV_STEPS];
        fits[k][l]  = top_r[k][l] >= {1'b0, dv[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DIV_STEPS:0], in_valid};
    end
    dv[0] <= divisor;
    for (int k = 0; k < DIV_STEPS - 1; k++) begin
      dv[k+1] <= dv[k];
    end
    for (int l = 0; l < LANES; l++) begin
      // |num| * 2^42 plus half the divisor, for round half away from zero
      acc[0][l] <= (ACC_W'(mag[l]) << NUM_SHIFT) | ACC_W'(divisor >> 1);
      neg[0][l] <= num[l][QW-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int l = 0; l < LANES; l++) begin
        neg[k+1][l] <= neg[k][l];
        acc[k+1][l] <= fits[k][l] ?
                       {top_r[k][l] - {1'b0, dv[k]}, sh[k][l][DIV_STEPS-1:1], 1'b1} :
                       sh[k][l];
      end
    end
    for (int l = 0; l < LANES; l++) begin
      quo[l] <= neg[DIV_STEPS][l] ? -Q_W'(acc[DIV_STEPS][l][DIV_STEPS-1:0]) :
                                    Q_W'(acc[DIV_STEPS][l][DIV_STEPS-1:0]);
    end
  end

  assign out_valid = vld[DIV_STEPS+1];
  assign quo_b     = quo[0];
  assign quo_c     = quo[1];
  assign quo_d     = quo[2];

endmodule

// ===== tb/quaternion_to_scaled_affine_core_tb.sv =====
`timescale 1ns / 1ps

module quaternion_to_scaled_affine_core_tb;
  import qsa_pkg::*;

  localparam int LATENCY   = 75;
  localparam int MAX_CYCLE = 400000;
  localparam int N_RANDOM  = 650;

  typedef logic [63:0] u64_t;

  function automatic u64_t root_floor(u64_t x);
    u64_t res;
    u64_t bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic u64_t root_nearest(u64_t x);
    u64_t r;
    r = root_floor(x);
    if (x - r * r > r) r++;
    return r;
  endfunction

  function automatic longint quot_away(longint num, u64_t den);
    u64_t m;
    m = (num < 0) ? u64_t'(-num) : u64_t'(num);
    m = (m + den / 2) / den;
    return (num < 0) ? -longint'(m) : longint'(m);
  endfunction

  // term is Q.56 as a 128-bit value
  function automatic logic signed [31:0] scale_term(logic signed [127:0] term, longint sp);
    logic signed [127:0] t;
    logic signed [127:0] p;
    logic [127:0] m;
    m = (term < 0) ? -term : term;
    m = (m + (128'd1 << 25)) >> 26;
    t = (term < 0) ? -$signed(m) : $signed(m);
    if (t > (128'sd1 <<< 31)) t = 128'sd1 <<< 31;
    if (t < -(128'sd1 <<< 31)) t = -(128'sd1 <<< 31);
    p = t * sp;
    m = (p < 0) ? -p : p;
    m = (m + (128'd1 << 29)) >> 30;
    p = (p < 0) ? -$signed(m) : $signed(m);
    if (p > 128'sd2147483647) p = 128'sd2147483647;
    if (p < -128'sd2147483648) p = -128'sd2147483648;
    return p[31:0];
  endfunction

  function automatic result_t affine_of(item_t it);
    result_t r;
    longint qb, qc, qd, s, asq, sx, sy, sz;
    longint a, b, c, d;
    u64_t n;
    logic signed [127:0] aa, bb, cc, dd, ab, ac, ad, bc, bd, cd;
    qb = it.quat_b; qc = it.quat_c; qd = it.quat_d;
    s = qb * qb + qc * qc + qd * qd;
    asq = (64'sd1 <<< 28) - s;
    if (asq < 27) begin
      n = root_nearest(u64_t'(s) << 28);
      if (n == 0) n = 1;
      a = 0;
      b = quot_away(qb * (64'sd1 <<< 42), n);
      c = quot_away(qc * (64'sd1 <<< 42), n);
      d = quot_away(qd * (64'sd1 <<< 42), n);
    end else begin
      a = longint'(root_nearest(u64_t'(asq) << 28));
      b = qb * 16384; c = qc * 16384; d = qd * 16384;
    end
    sx = it.spacing_x; sy = it.spacing_y; sz = it.spacing_z;
    if (sx <= 0) sx = 65536;
    if (sy <= 0) sy = 65536;
    if (sz <= 0) sz = 65536;
    if (it.left_handed) sz = -sz;
    aa = 128'(a) * a; bb = 128'(b) * b; cc = 128'(c) * c; dd = 128'(d) * d;
    ab = 128'(a) * b; ac = 128'(a) * c; ad = 128'(a) * d;
    bc = 128'(b) * c; bd = 128'(b) * d; cd = 128'(c) * d;
    r.m00 = scale_term(aa + bb - cc - dd, sx);
    r.m01 = scale_term(2 * (bc - ad), sy);
    r.m02 = scale_term(2 * (bd + ac), sz);
    r.m10 = scale_term(2 * (bc + ad), sx);
    r.m11 = scale_term(aa + cc - bb - dd, sy);
    r.m12 = scale_term(2 * (cd - ab), sz);
    r.m20 = scale_term(2 * (bd - ac), sx);
    r.m21 = scale_term(2 * (cd + ab), sy);
    r.m22 = scale_term(aa + dd - cc - bb, sz);
    r.trans_x = it.offset_x;
    r.trans_y = it.offset_y;
    r.trans_z = it.offset_z;
    return r;
  endfunction

  class affine_scoreboard;
    result_t pending[$];
    int errors;
    int matched;

    function void note_transfer(item_t it);
      pending.push_back(affine_of(it));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("result with none pending");
        errors++;
        return;
      end
      want = pending.pop_front();
      matched++;
      if (got.m00 !== want.m00) begin $error("m00 exp %0d got %0d", want.m00, got.m00); errors++; end
      if (got.m01 !== want.m01) begin $error("m01 exp %0d got %0d", want.m01, got.m01); errors++; end
      if (got.m02 !== want.m02) begin $error("m02 exp %0d got %0d", want.m02, got.m02); errors++; end
      if (got.m10 !== want.m10) begin $error("m10 exp %0d got %0d", want.m10, got.m10); errors++; end
      if (got.m11 !== want.m11) begin $error("m11 exp %0d got %0d", want.m11, got.m11); errors++; end
      if (got.m12 !== want.m12) begin $error("m12 exp %0d got %0d", want.m12, got.m12); errors++; end
      if (got.m20 !== want.m20) begin $error("m20 exp %0d got %0d", want.m20, got.m20); errors++; end
      if (got.m21 !== want.m21) begin $error("m21 exp %0d got %0d", want.m21, got.m21); errors++; end
      if (got.m22 !== want.m22) begin $error("m22 exp %0d got %0d", want.m22, got.m22); errors++; end
      if (got.trans_x !== want.trans_x) begin
        $error("trans_x exp %0d got %0d", want.trans_x, got.trans_x); errors++;
      end
      if (got.trans_y !== want.trans_y) begin
        $error("trans_y exp %0d got %0d", want.trans_y, got.trans_y); errors++;
      end
      if (got.trans_z !== want.trans_z) begin
        $error("trans_z exp %0d got %0d", want.trans_z, got.trans_z); errors++;
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   operand = '0;
  logic    done;
  result_t result;

  affine_scoreboard sb = new();
  int cycle = 0;
  int idle_pct = 0;
  int n_sent = 0;
  int n_degen = 0;

  always #5 clk = ~clk;

  quaternion_to_scaled_affine_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operand(operand), .done(done), .result(result)
  );

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst && start && !busy) sb.note_transfer(operand);
    if (!rst && done) sb.check_result(result);
    if (cycle >= MAX_CYCLE) begin
      $display("timeout at cycle %0d", cycle);
      $display("TB_ERROR");
      $finish;
    end
  end

  // presents one item, holds it until transfer; gaps drawn from idle_pct
  task automatic send_item(item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operand <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_spacing();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return {1'b1, 31'($urandom)};
      2: return 32'h7FFF_FFFF;
      3: return 32'(1 + $urandom_range(65536 * 8));
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int b, c, d;
    real nrm;
    it.offset_x = $urandom; it.offset_y = $urandom; it.offset_z = $urandom;
    it.spacing_x = rand_spacing();
    it.spacing_y = rand_spacing();
    it.spacing_z = rand_spacing();
    it.left_handed = 1'($urandom_range(1));
    case ($urandom_range(9))
      0, 1: begin
        it.quat_b = 16'($urandom); it.quat_c = 16'($urandom); it.quat_d = 16'($urandom);
      end
      2: begin
        // near the unit sphere: real part close to zero, may be degenerate
        b = int'($urandom_range(32767)) - 16384;
        c = int'($urandom_range(32767)) - 16384;
        d = int'($urandom_range(32767)) - 16384;
        nrm = $sqrt(real'(b * b + c * c + d * d)) + 0.001;
        it.quat_b = 16'(int'(b * 16384.0 / nrm));
        it.quat_c = 16'(int'(c * 16384.0 / nrm));
        it.quat_d = 16'(int'(d * 16384.0 / nrm));
      end
      default: begin
        it.quat_b = 16'(int'($urandom_range(18000)) - 9000);
        it.quat_c = 16'(int'($urandom_range(18000)) - 9000);
        it.quat_d = 16'(int'($urandom_range(18000)) - 9000);
      end
    endcase
    return it;
  endfunction

  function automatic item_t make_item(logic [15:0] b, logic [15:0] c, logic [15:0] d,
                                      logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                      logic lh);
    item_t it;
    it.quat_b = b; it.quat_c = c; it.quat_d = d;
    it.offset_x = $urandom; it.offset_y = $urandom; it.offset_z = $urandom;
    it.spacing_x = sx; it.spacing_y = sy; it.spacing_z = sz;
    it.left_handed = lh;
    return it;
  endfunction

  initial begin
    item_t it;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(make_item(16'h0, 16'h0, 16'h0, 32'h10000, 32'h10000, 32'h10000, 1'b0));
    send_item(make_item(16'h0, 16'h0, 16'h0, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1));
    send_item(make_item(16'h4000, 16'h0, 16'h0, 32'h20000, 32'h30000, 32'h1, 1'b0));
    send_item(make_item(16'h0, 16'h4000, 16'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 1'b1));
    send_item(make_item(16'h0, 16'h0, 16'hC000, 32'h7FFF_FFFF, 32'h1, 32'h10000, 1'b0));
    send_item(make_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h10000,
                        32'h7FFF_FFFF, 1'b1));
    send_item(make_item(16'h8000, 16'h8000, 16'h8000, 32'h10000, 32'h7FFF_FFFF,
                        32'h0, 1'b0));
    send_item(make_item(16'h7FFF, 16'h8000, 16'h0001, 32'h1, 32'h1, 32'h1, 1'b1));
    send_item(make_item(16'h2000, 16'h2000, 16'h2000, 32'h18000, 32'h8000, 32'h4000, 1'b0));
    send_item(make_item(16'h3FFF, 16'h0, 16'h0, 32'h10000, 32'h10000, 32'h10000, 1'b0));
    send_item(make_item(16'h2D41, 16'h2D41, 16'h0, 32'h10000, 32'h10000, 32'h10000, 1'b1));
    send_item(make_item(16'h0, 16'h0, 16'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        1'b1));
    it = make_item(16'h1234, 16'hEDCB, 16'h0F0F, 32'h10000, 32'h10000, 32'h10000, 1'b0);
    it.offset_x = 32'h8000_0000; it.offset_y = 32'h7FFF_FFFF; it.offset_z = 32'hFFFF_FFFF;
    send_item(it);
    it.offset_x = 32'h0; it.offset_y = 32'h0; it.offset_z = 32'h0;
    send_item(it);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 38 : (phase == 1) ? 47 : 0;
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        it = rand_item();
        if (longint'(it.quat_b) * it.quat_b + longint'(it.quat_c) * it.quat_c +
            longint'(it.quat_d) * it.quat_d > 64'sd268435456 - 27) n_degen++;
        send_item(it);
        if ($urandom_range(199) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d items, %0d with a degenerate real part, %0d results checked",
             n_sent, n_degen, sb.matched);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
